// File: sv/assert_macros.svh
// Shared assertion macros. Clock and reset names follow the project
// convention (aclk, active-low synchronous aresetn).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define QP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define QP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/qprelu_pkg.sv
`timescale 1ns / 1ps

package qprelu_pkg;

    // Table and fixed-point setup
    localparam int MAX_CHANNELS    = 256;
    localparam int SLOPE_FRAC_BITS = 12;
    localparam int MULT_FRAC_BITS  = 16;
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int SLOPE_W    = 16;
    localparam int MULT_W     = 24;
    localparam int RUN_W      = 20;
    localparam int CNT_W      = 9;
    localparam int POS_CH_W   = 8;
    localparam int ZP_W       = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Datapath widths
    localparam int X_W    = BYTE_W + 1;
    localparam int V_W    = X_W + SLOPE_W;
    localparam int T_W    = V_W + MULT_W + 1;
    localparam int FRAC_W = SLOPE_FRAC_BITS + MULT_FRAC_BITS;
    localparam int TB_W   = T_W + 1;
    localparam int R_W    = TB_W - FRAC_W;

    // Output limits
    localparam int OUT_U_MAX = 255;
    localparam int OUT_S_MAX = 127;
    localparam int OUT_S_MIN = -127;

    // Upper bound on the channel count; the position counter wraps after at most this many channels
    localparam int POS_CH_LIMIT = 1 << POS_CH_W;

    // Input commands
    localparam logic CMD_LOAD_SLOPE = 1'b0;
    localparam logic CMD_ELEMENT    = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_ZP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ZP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUANT_MULT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_CHANNEL  = 3'd6;

    localparam logic [MULT_W-1:0] REQUANT_MULT_RESET = 24'd65536;

    // Element sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_MULT,
        ST_BIAS,
        ST_ROUND
    } state_t;

endpackage

// File: sv/quantized_prelu_activation_core.sv
`timescale 1ns / 1ps
// Quantized per-channel PReLU, one tensor element per input transaction.
// A slope-load transaction (command 0) writes one signed Q4.12 entry of the
// 256-entry slope memory; loads may arrive back to back while the core is idle.
// An element transaction (command 1) reads its channel's slope from the
// memory as it is accepted, then walks through four steps of the shared
// datapath (slope scale, requant multiply, zero-point bias, round and clamp),
// and no new transaction is accepted until the round step completes and the
// core returns to idle. The result sits in an output register, so the next
// element may start while the previous result waits for m_ready; its round
// step then holds until that earlier result is taken. Slope entries are
// undefined until loaded; the position counters restart on tensor_start.
// Configuration writes are taken at any cycle but must only be issued while
// the core is idle.
`include "assert_macros.svh"

module quantized_prelu_activation_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_we,
    input  logic [qprelu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qprelu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_command,
    input  logic [qprelu_pkg::BYTE_W-1:0]          s_element_byte,
    input  logic                                   s_tensor_start,
    input  logic [7:0]                             s_slope_index,
    input  logic signed [qprelu_pkg::SLOPE_W-1:0]  s_slope_value,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [qprelu_pkg::BYTE_W-1:0]          m_result_byte,
    output logic                                   m_was_clamped
);
    import qprelu_pkg::*;

    // Configuration registers
    logic                  signed_mode_reg;
    logic [ZP_W-1:0]       in_zp_reg;
    logic [ZP_W-1:0]       out_zp_reg;
    logic [MULT_W-1:0]     requant_mult_reg;
    logic [RUN_W-1:0]      run_length_reg;
    logic [CNT_W-1:0]      channels_reg;
    logic                  per_channel_reg;

    // Position counters
    logic [RUN_W-1:0]      run_pos_reg;
    logic [RUN_W-1:0]      run_pos_next;
    logic [POS_CH_W-1:0]   ch_pos_reg;
    logic [POS_CH_W-1:0]   ch_pos_next;

    // Sequencer
    state_t                state_reg;
    state_t                state_next;

    // Slope memory
    logic signed [SLOPE_W-1:0] slope_mem [MAX_CHANNELS];
    logic signed [SLOPE_W-1:0] slope_rd_reg;
    logic                      slope_zero_reg;

    // Datapath registers
    logic signed [X_W-1:0]  x_reg;
    logic signed [X_W-1:0]  x_next;
    logic signed [V_W-1:0]  v_reg;
    logic signed [V_W-1:0]  v_next;
    logic signed [T_W-1:0]  t_reg;
    logic signed [T_W-1:0]  t_next;
    logic signed [TB_W-1:0] tb_reg;
    logic signed [TB_W-1:0] tb_next;

    // Output register
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [BYTE_W-1:0]      result_reg;
    logic [BYTE_W-1:0]      result_next;
    logic                   clamped_reg;
    logic                   clamped_next;

    // Handshake decode
    logic                   in_fire;
    logic                   load_fire;
    logic                   elem_fire;
    logic                   round_fire;

    // Channel selection
    logic [RUN_W-1:0]       run_cur;
    logic [POS_CH_W-1:0]    ch_cur;
    logic [POS_CH_W-1:0]    ch_sel;
    logic                   ch_out_of_range;
    logic                   load_in_range;
    logic [CH_W-1:0]        rd_addr;
    logic [RUN_W-1:0]       run_len_eff;
    logic [CNT_W-1:0]       count_eff;
    logic [RUN_W-1:0]       run_inc;
    logic [POS_CH_W:0]      ch_inc;

    // Rounding and clamping
    logic signed [SLOPE_W-1:0]   slope_eff;
    logic [ZP_W+FRAC_W-1:0]      bias_term;
    logic [FRAC_W-1:0]           half_term;
    logic signed [TB_W-1:0]      rnd_sum;
    logic signed [R_W-1:0]       r_int;
    logic signed [R_W-1:0]       lim_hi;
    logic signed [R_W-1:0]       lim_lo;

    // ------------------------------------------------------------------
    // Configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_mode_reg  <= 1'b0;
            in_zp_reg        <= '0;
            out_zp_reg       <= '0;
            requant_mult_reg <= REQUANT_MULT_RESET;
            run_length_reg   <= RUN_W'(1);
            channels_reg     <= CNT_W'(1);
            per_channel_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SIGNED_MODE:  signed_mode_reg  <= cfg_wdata[0];
                CFG_IN_ZP:        in_zp_reg        <= cfg_wdata[ZP_W-1:0];
                CFG_OUT_ZP:       out_zp_reg       <= cfg_wdata[ZP_W-1:0];
                CFG_REQUANT_MULT: requant_mult_reg <= cfg_wdata[MULT_W-1:0];
                CFG_RUN_LENGTH:   run_length_reg   <= cfg_wdata[RUN_W-1:0];
                CFG_CHANNELS:     channels_reg     <= cfg_wdata[CNT_W-1:0];
                CFG_PER_CHANNEL:  per_channel_reg  <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    assign in_fire   = s_valid && s_ready;
    assign load_fire = in_fire && (s_command == CMD_LOAD_SLOPE);
    assign elem_fire = in_fire && (s_command == CMD_ELEMENT);

    // ------------------------------------------------------------------
    // Channel tracking: tensor_start clears the counters before this element
    always_comb begin
        run_cur     = s_tensor_start ? '0 : run_pos_reg;
        ch_cur      = s_tensor_start ? '0 : ch_pos_reg;
        ch_sel      = per_channel_reg ? ch_cur : '0;
        run_len_eff = (run_length_reg == '0) ? RUN_W'(1) : run_length_reg;
        if (channels_reg == '0) begin
            count_eff = CNT_W'(1);
        end else if (32'(channels_reg) > POS_CH_LIMIT) begin
            count_eff = CNT_W'(POS_CH_LIMIT);
        end else begin
            count_eff = channels_reg;
        end
        run_inc = run_cur + RUN_W'(1);
        ch_inc  = {1'b0, ch_cur} + (POS_CH_W+1)'(1);
        if (run_inc >= run_len_eff) begin
            run_pos_next = '0;
            ch_pos_next  = (CNT_W'(ch_inc) >= count_eff) ? '0 : ch_inc[POS_CH_W-1:0];
        end else begin
            run_pos_next = run_inc;
            ch_pos_next  = ch_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_pos_reg <= '0;
            ch_pos_reg  <= '0;
        end else if (elem_fire) begin
            run_pos_reg <= run_pos_next;
            ch_pos_reg  <= ch_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Slope memory: write on load, registered read on element accept
    assign ch_out_of_range = 32'(ch_sel) >= MAX_CHANNELS;
    assign load_in_range   = 32'(s_slope_index) < MAX_CHANNELS;
    assign rd_addr         = CH_W'(ch_sel);

    always_ff @(posedge aclk) begin
        if (load_fire && load_in_range) begin
            slope_mem[CH_W'(s_slope_index)] <= s_slope_value;
        end
        if (elem_fire) begin
            slope_rd_reg   <= slope_mem[rd_addr];
            slope_zero_reg <= ch_out_of_range;
        end
    end

    // ------------------------------------------------------------------
    // Input offset: subtract zero point, or sign-extend in signed mode
    always_comb begin
        if (signed_mode_reg) begin
            x_next = X_W'($signed(s_element_byte));
        end else begin
            x_next = $signed({1'b0, s_element_byte}) - $signed({1'b0, in_zp_reg});
        end
    end

    // Negative side scaled by slope, positive side promoted to Q.12
    assign slope_eff = slope_zero_reg ? '0 : slope_rd_reg;

    always_comb begin
        if (x_reg < 0) begin
            v_next = x_reg * slope_eff;
        end else begin
            v_next = V_W'(x_reg) <<< SLOPE_FRAC_BITS;
        end
    end

    // Requant multiply (unsigned multiplier)
    assign t_next = v_reg * $signed({1'b0, requant_mult_reg});

    // Output zero point in unsigned mode
    assign bias_term = signed_mode_reg ? '0 : {out_zp_reg, {FRAC_W{1'b0}}};
    assign tb_next   = t_reg + $signed({1'b0, bias_term});

    // Round half away from zero: add half, less one when negative, then floor
    assign half_term = (tb_reg < 0) ? {1'b0, {(FRAC_W-1){1'b1}}}
                                    : {1'b1, {(FRAC_W-1){1'b0}}};
    assign rnd_sum   = tb_reg + $signed({1'b0, half_term});
    assign r_int     = rnd_sum[TB_W-1:FRAC_W];

    // Clamp
    assign lim_hi = signed_mode_reg ? R_W'(OUT_S_MAX) : R_W'(OUT_U_MAX);
    assign lim_lo = signed_mode_reg ? R_W'(OUT_S_MIN) : R_W'(0);

    always_comb begin
        if (r_int > lim_hi) begin
            result_next  = lim_hi[BYTE_W-1:0];
            clamped_next = 1'b1;
        end else if (r_int < lim_lo) begin
            result_next  = lim_lo[BYTE_W-1:0];
            clamped_next = 1'b1;
        end else begin
            result_next  = r_int[BYTE_W-1:0];
            clamped_next = 1'b0;
        end
    end

    // Datapath registers advance with the sequencer
    always_ff @(posedge aclk) begin
        if (elem_fire) begin
            x_reg <= x_next;
        end
        if (state_reg == ST_SCALE) begin
            v_reg <= v_next;
        end
        if (state_reg == ST_MULT) begin
            t_reg <= t_next;
        end
        if (state_reg == ST_BIAS) begin
            tb_reg <= tb_next;
        end
        if (round_fire) begin
            result_reg  <= result_next;
            clamped_reg <= clamped_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (elem_fire) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_MULT;
            ST_MULT:  state_next = ST_BIAS;
            ST_BIAS:  state_next = ST_ROUND;
            ST_ROUND: begin
                if (round_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_ready    = 1'b0;
        round_fire = 1'b0;
        case (state_reg)
            ST_IDLE:  s_ready    = 1'b1;
            ST_ROUND: round_fire = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Output valid: set by the round step, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (round_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_byte = result_reg;
    assign m_was_clamped = clamped_reg;

    // ------------------------------------------------------------------
    // Assertions
    `QP_ASSERT(a_busy_not_ready, (state_reg != ST_IDLE) |-> !s_ready, "ready while busy")
    `QP_ASSERT_NEXT(a_elem_starts, elem_fire, state_reg == ST_SCALE, "element did not start")
    `QP_ASSERT_NEXT(a_round_delivers, (state_reg == ST_ROUND) && !m_valid_reg, m_valid_reg && (state_reg == ST_IDLE), "round step did not fill output")

endmodule
